### rtl/core/rdrq_pkg.sv
// ----------------------------------------------------------------------------
// Disk request queue package
// Shared widths, codes, entry and result types, and the rotational
// distance function used by the request sequencer.
// ----------------------------------------------------------------------------
package rdrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SECTOR_BITS = 12;

    localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int PROC_W   = 8;
    localparam int REQ_W    = 8;
    localparam int SC_W     = 13;
    localparam int TPS_W    = 16;
    localparam int WAIT_W   = 28;
    localparam int QCOUNT_W = 5;
    localparam int MODE_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Signed distance wide enough for target - current + sector_count.
    localparam int DIST_W = ((SECTOR_BITS > SC_W) ? SECTOR_BITS : SC_W) + 2;
    localparam int DMAG_W = DIST_W - 1;
    localparam int PROD_W = TPS_W + DMAG_W;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

    localparam logic REG_SECTOR_COUNT    = 1'b0;
    localparam logic REG_TIME_PER_SECTOR = 1'b1;

    localparam logic [SC_W-1:0]  SECTOR_COUNT_RST    = SC_W'(4096);
    localparam logic [TPS_W-1:0] TIME_PER_SECTOR_RST = TPS_W'(1);

    typedef struct packed {
        logic [PROC_W-1:0]      proc;
        logic [REQ_W-1:0]       req;
        logic                   wr;
        logic [SECTOR_BITS-1:0] sec;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [SC_W-1:0]  sector_count;
        logic [TPS_W-1:0] time_per_sector;
    } cfg_t;

    typedef struct packed {
        logic                head_valid;
        logic [WAIT_W-1:0]   head_wait;
        logic [PROC_W-1:0]   head_process;
        logic [REQ_W-1:0]    head_request;
        logic                head_is_write;
        logic [QCOUNT_W-1:0] queue_count;
        logic                error;
    } result_t;

    // Forward distance from cur to tgt; a zero or negative step wraps by one track.
    function automatic logic signed [DIST_W-1:0] rot_dist(
        input logic [SECTOR_BITS-1:0] tgt,
        input logic [SECTOR_BITS-1:0] cur,
        input logic [SC_W-1:0]        sc
    );
        logic signed [DIST_W-1:0] d;
        d = $signed(DIST_W'(tgt)) - $signed(DIST_W'(cur));
        if (d <= 0)
        begin
            d = d + $signed(DIST_W'(sc));
        end
        return d;
    endfunction

endpackage

### rtl/core/rdrq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module rdrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/rdrq_cfg.sv
// ----------------------------------------------------------------------------
// Disk request queue configuration registers
// APB-style register file holding sector count and time per sector.
// ----------------------------------------------------------------------------
module rdrq_cfg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [rdrq_pkg::PADDR_W-1:0] paddr,
    input  logic [rdrq_pkg::PDATA_W-1:0] pwdata,
    output logic [rdrq_pkg::PDATA_W-1:0] prdata,
    output logic                   pready,
    output rdrq_pkg::cfg_t         cfg
);
    import rdrq_pkg::*;

    logic [SC_W-1:0]  sector_count_reg;
    logic [TPS_W-1:0] time_per_sector_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg    <= SECTOR_COUNT_RST;
            time_per_sector_reg <= TIME_PER_SECTOR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SECTOR_COUNT:    sector_count_reg    <= pwdata[SC_W-1:0];
                REG_TIME_PER_SECTOR: time_per_sector_reg <= pwdata[TPS_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SECTOR_COUNT:    prdata = PDATA_W'(sector_count_reg);
            REG_TIME_PER_SECTOR: prdata = PDATA_W'(time_per_sector_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.sector_count    = sector_count_reg;
    assign cfg.time_per_sector = time_per_sector_reg;

endmodule

### rtl/core/rdrq_seq.sv
// ----------------------------------------------------------------------------
// Disk request queue sequencer
// Sweeps the request table RAM to insert or pop, reads the head and
// computes its rotational wait into the result register.
// ----------------------------------------------------------------------------
module rdrq_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rdrq_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rdrq_pkg::MODE_W-1:0]       mode,
    input  logic [rdrq_pkg::PROC_W-1:0]       process_id,
    input  logic [rdrq_pkg::REQ_W-1:0]        request_id,
    input  logic                              is_write,
    input  logic [rdrq_pkg::SECTOR_BITS-1:0]  sector,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rdrq_pkg::result_t                 result
);
    import rdrq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_HDAT = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SECTOR_BITS-1:0]    cur_reg, cur_next;
    logic                      err_reg, err_next;
    logic                      placed_reg, placed_next;
    entry_t                    new_reg, new_next;
    entry_t                    hold_reg, hold_next;
    entry_t                    hd_reg, hd_next;
    logic signed [DIST_W-1:0]  dn_reg, dn_next;
    logic [DMAG_W-1:0]         dpos_reg, dpos_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   res_reg, res_next;

    logic                      we;
    logic [ADDR_W-1:0]         wr_addr;
    entry_t                    wr_data;
    logic [ADDR_W-1:0]         rd_addr;
    entry_t                    rd_data;
    logic [ENTRY_W-1:0]        rd_bits;

    logic [CNT_W-1:0]          j;
    logic signed [DIST_W-1:0]  dist_rd;
    logic [PROD_W-1:0]         prod;
    logic [WAIT_W-1:0]         wait_sat;
    logic                      accept;
    logic                      load_out;

    rdrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data  = entry_t'(rd_bits);
    assign j        = k_reg - CNT_W'(1);
    assign dist_rd  = rot_dist(rd_data.sec, cur_reg, cfg.sector_count);
    assign prod     = PROD_W'(cfg.time_per_sector) * PROD_W'(dpos_reg);
    assign wait_sat = (|prod[PROD_W-1:WAIT_W]) ? {WAIT_W{1'b1}} : prod[WAIT_W-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign load_out = (state_reg == S_MUL) & (~out_valid_reg | out_ready);

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        err_next    = err_reg;
        placed_next = placed_reg;
        new_next    = new_reg;
        hold_next   = hold_reg;
        hd_next     = hd_reg;
        dn_next     = dn_reg;
        dpos_next   = dpos_reg;
        res_next    = res_reg;
        we          = 1'b0;
        wr_addr     = j[ADDR_W-1:0];
        wr_data     = placed_reg ? hold_reg : new_reg;
        rd_addr     = k_reg[ADDR_W-1:0];
        out_valid_next = out_valid_reg & ~out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next        = '0;
                    placed_next   = 1'b0;
                    err_next      = 1'b0;
                    new_next.proc = process_id;
                    new_next.req  = request_id;
                    new_next.wr   = is_write;
                    new_next.sec  = sector;
                    dn_next       = rot_dist(sector, cur_reg, cfg.sector_count);
                    priority if (mode == MODE_INSERT)
                    begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            err_next   = 1'b1;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else if (mode == MODE_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next   = 1'b1;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_REM;
                        end
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end

            // Read entry k while entry k-1 is decided and written back.
            S_INS:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg != '0)
                begin
                    if (j == count_reg)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_HEAD;
                    end
                    else if (placed_reg || (dist_rd > dn_reg))
                    begin
                        we          = 1'b1;
                        hold_next   = rd_data;
                        placed_next = 1'b1;
                    end
                end
            end

            // Entry 0 moves the head position; every later entry moves down one slot.
            S_REM:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg != '0)
                begin
                    if (j == '0)
                    begin
                        cur_next = rd_data.sec;
                    end
                    else
                    begin
                        we      = 1'b1;
                        wr_addr = ADDR_W'(j - CNT_W'(1));
                        wr_data = rd_data;
                    end
                    if (j == count_reg - CNT_W'(1))
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_HEAD;
                    end
                end
            end

            S_HEAD:
            begin
                rd_addr    = '0;
                state_next = S_HDAT;
            end

            S_HDAT:
            begin
                hd_next    = rd_data;
                dpos_next  = (dist_rd > 0) ? dist_rd[DMAG_W-1:0] : '0;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                if (load_out)
                begin
                    out_valid_next         = 1'b1;
                    res_next.queue_count   = QCOUNT_W'(count_reg);
                    res_next.error         = err_reg;
                    if (count_reg != '0)
                    begin
                        res_next.head_valid    = 1'b1;
                        res_next.head_wait     = wait_sat;
                        res_next.head_process  = hd_reg.proc;
                        res_next.head_request  = hd_reg.req;
                        res_next.head_is_write = hd_reg.wr;
                    end
                    else
                    begin
                        res_next.head_valid    = 1'b0;
                        res_next.head_wait     = '0;
                        res_next.head_process  = '0;
                        res_next.head_request  = '0;
                        res_next.head_is_write = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        err_reg    <= err_next;
        placed_reg <= placed_next;
        new_reg    <= new_next;
        hold_reg   <= hold_next;
        hd_reg     <= hd_next;
        dn_reg     <= dn_next;
        dpos_reg   <= dpos_next;
        res_reg    <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

### rtl/core/rotational_disk_request_queue_top.sv
// ----------------------------------------------------------------------------
// Rotational disk request queue
// Shortest rotational latency first scheduler over a 16-entry request table.
//
//   Port group    Handshake                   Contents
//   ----------    -------------------------   --------------------------------
//   apb           psel/penable/pwrite/pready  sector_count, time_per_sector
//   request in    in_valid/in_ready           mode, ids, is_write, sector
//   result out    out_valid/out_ready         head fields, count, error
//
// One transaction is in work at a time; the table RAM is swept one entry
// per cycle. An insert or remove that is not refused first sweeps the table;
// the head is then read, its wait computed and the result register loaded once free.
// The next transaction is accepted while a result still waits on out_ready.
// Reset empties the queue and sets the head position to sector 0.
// ----------------------------------------------------------------------------
module rotational_disk_request_queue_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdrq_pkg::PADDR_W-1:0]      paddr,
    input  logic [rdrq_pkg::PDATA_W-1:0]      pwdata,
    output logic [rdrq_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rdrq_pkg::MODE_W-1:0]       mode,
    input  logic [rdrq_pkg::PROC_W-1:0]       process_id,
    input  logic [rdrq_pkg::REQ_W-1:0]        request_id,
    input  logic                              is_write,
    input  logic [rdrq_pkg::SECTOR_BITS-1:0]  sector,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              head_valid,
    output logic [rdrq_pkg::WAIT_W-1:0]       head_wait,
    output logic [rdrq_pkg::PROC_W-1:0]       head_process,
    output logic [rdrq_pkg::REQ_W-1:0]        head_request,
    output logic                              head_is_write,
    output logic [rdrq_pkg::QCOUNT_W-1:0]     queue_count,
    output logic                              error
);
    import rdrq_pkg::*;

    cfg_t    cfg;
    result_t result;

    rdrq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rdrq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .process_id (process_id),
        .request_id (request_id),
        .is_write   (is_write),
        .sector     (sector),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign head_valid    = result.head_valid;
    assign head_wait     = result.head_wait;
    assign head_process  = result.head_process;
    assign head_request  = result.head_request;
    assign head_is_write = result.head_is_write;
    assign queue_count   = result.queue_count;
    assign error         = result.error;

endmodule
